// ===== src/eth_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eth_pkg: expiry timer heap shared types
// command and result beat structs, command and status codes, fsm states
// ----------------------------------------------------------------------------
package eth_pkg;

    // deadline width: 48-bit time plus 40-bit ttl
    localparam int DL_W = 49;
    localparam int NOW_W = 48;
    localparam int TTL_W = 40;
    // divide by 1000 in 16-bit digits over a 64-bit dividend
    localparam int DIV_STEPS = 4;
    localparam logic [10:0] MS_PER_S = 11'd1000;
    // ceil(2^36 / 1000), exact for dividends below 2^26
    localparam logic [26:0] DIV_RECIP = 27'd68719477;
    localparam logic [49:0] TTL_SAT = 50'h7F_FFFF_FFFF;
    localparam logic signed [39:0] TTL_MISSING = -40'sd1;
    localparam logic signed [39:0] TTL_GONE = -40'sd2;

    localparam logic [2:0] CMD_SET = 3'd0;
    localparam logic [2:0] CMD_DEL = 3'd1;
    localparam logic [2:0] CMD_ASK_EXP = 3'd2;
    localparam logic [2:0] CMD_ASK_TTL = 3'd3;
    localparam logic [2:0] CMD_SWEEP = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_BAD_TTL = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] key;
        logic [1:0]  engine;
        logic [39:0] ttl_ms;
        logic [47:0] now_ms;
        logic [4:0]  budget;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic               expired_flag;
        logic signed [39:0] ttl_seconds;
        logic [31:0]        removed_key;
        logic [1:0]         removed_engine;
        logic [4:0]         removed_count;
        logic               last;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_DIV,
        S_DIV_END,
        S_SW_RD,
        S_SW_CHK,
        S_RM_START,
        S_RM_LD,
        S_DN_RL,
        S_DN_RR,
        S_DN_DEC,
        S_UP_RD,
        S_UP_DEC,
        S_DONE
    } t_state;

endpackage

// ===== src/eth_slot_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eth_slot_ram: heap slot memory
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module eth_slot_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 83
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/expiry_timer_heap_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expiry_timer_heap_core: key expiry table on a binary min-heap
// set, delete, expiry queries and budgeted sweeps over a slot memory
// ----------------------------------------------------------------------------
// usage:
//   a command beat is taken on a rising edge with start high and busy low;
//   busy stays high until the cycle the last result beat sits on o_rsp,
//   and a new command can be taken in that cycle.
//   results leave on o_rsp with o_strobe high for one cycle each; the
//   receiver cannot hold them off. o_rsp.last marks the final beat.
// command flow:
//   every command except a sweep, an unknown code and a set with a zero
//   ttl first scans the table for its key, one slot per cycle. a set or a
//   delete then walks the heap by sift down or sift up, both bounded by
//   log2(CAPACITY) levels. ask ttl adds a divide by 1000, 16 dividend bits
//   a cycle by reciprocal multiply, then a rounding step. a sweep reads and
//   checks the root, then does one removal (sift) per popped entry. every
//   command ends in a report state and its last beat leaves in the cycle
//   after it. the key scan and the one read a cycle of the slot memory set
//   the pace.
// reset:
//   synchronous active-low reset empties the table (count to zero); slot
//   memory contents are left as they are and are never read above count.
// ----------------------------------------------------------------------------
module expiry_timer_heap_core #(
    parameter int CAPACITY = 256,
    parameter int MAX_BUDGET = 16,
    parameter int KEY_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  eth_pkg::t_cmd i_cmd,
    output logic          busy,
    output logic          o_strobe,
    output eth_pkg::t_rsp o_rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;
    localparam int BW = $clog2(MAX_BUDGET + 1);
    localparam int DLW = eth_pkg::DL_W;
    localparam int EW = KEY_BITS + 2 + DLW;

    // control state
    eth_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_strobe, n_strobe;

    // working registers
    eth_pkg::t_cmd r_cmd, n_cmd;
    eth_pkg::t_rsp r_rsp, n_rsp;
    logic [EW-1:0] r_elem, n_elem;
    logic [EW-1:0] r_lft, n_lft;
    logic [AW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_sidx, n_sidx;
    logic          r_pv, n_pv;
    logic [AW-1:0] r_pidx, n_pidx;
    logic          r_hasr, n_hasr;
    logic [BW-1:0] r_budget, n_budget;
    logic [BW-1:0] r_removed, n_removed;
    logic [1:0]    r_status, n_status;
    logic          r_flag, n_flag;
    logic signed [eth_pkg::TTL_W-1:0] r_ttl_s, n_ttl_s;
    logic [63:0]    r_dvd, n_dvd;
    logic [9:0]     r_pr, n_pr;
    logic [5:0]     r_div_n, n_div_n;

    // memory port
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [EW-1:0] rd_data;

    eth_slot_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd_data)
    );

    // slot fields: {key, engine, deadline}
    logic [KEY_BITS-1:0] rd_key, key_in;
    logic [1:0]          rd_eng;
    logic [DLW-1:0]      rd_dl, elem_dl, lft_dl, now_x, new_dl, best_dl;
    logic [XW-1:0]       lidx, ridx, cnt_x;
    logic [AW-1:0]       pidx;
    logic [CW-1:0]       cnt_m1;
    logic                go_l, go_r;
    logic [25:0]         div_t;
    logic [52:0]         div_prod;
    logic [15:0]         div_qd;
    logic [25:0]         div_rem;
    logic [49:0]         sec;
    eth_pkg::t_state     after_st;

    always_comb begin
        rd_key  = rd_data[EW-1 -: KEY_BITS];
        rd_eng  = rd_data[DLW+1:DLW];
        rd_dl   = rd_data[DLW-1:0];
        elem_dl = r_elem[DLW-1:0];
        lft_dl  = r_lft[DLW-1:0];
        key_in  = KEY_BITS'(64'(r_cmd.key));
        now_x   = DLW'(r_cmd.now_ms);
        new_dl  = DLW'(r_cmd.now_ms) + DLW'(r_cmd.ttl_ms);
        lidx    = XW'({r_idx, 1'b1});
        ridx    = lidx + XW'(1);
        cnt_x   = XW'(r_cnt);
        pidx    = AW'((r_idx - AW'(1)) >> 1);
        cnt_m1  = r_cnt - CW'(1);
        go_l    = lft_dl < elem_dl;
        best_dl = go_l ? lft_dl : elem_dl;
        go_r    = r_hasr && (rd_dl < best_dl);
        // one 16-bit quotient digit: remainder and next dividend digit
        div_t    = {r_pr, r_dvd[63:48]};
        div_prod = 53'(div_t) * 53'(eth_pkg::DIV_RECIP);
        div_qd   = div_prod[51:36];
        div_rem  = div_t - 26'(div_qd) * 26'(eth_pkg::MS_PER_S);
        sec     = 50'(r_dvd) + 50'(r_pr != 10'd0);
        // sweeps return to the pop loop, everything else reports
        after_st = (r_cmd.command == eth_pkg::CMD_SWEEP) ? eth_pkg::S_SW_RD
                                                          : eth_pkg::S_DONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= eth_pkg::S_IDLE;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_rsp     <= n_rsp;
        r_elem    <= n_elem;
        r_lft     <= n_lft;
        r_idx     <= n_idx;
        r_sidx    <= n_sidx;
        r_pv      <= n_pv;
        r_pidx    <= n_pidx;
        r_hasr    <= n_hasr;
        r_budget  <= n_budget;
        r_removed <= n_removed;
        r_status  <= n_status;
        r_flag    <= n_flag;
        r_ttl_s   <= n_ttl_s;
        r_dvd     <= n_dvd;
        r_pr      <= n_pr;
        r_div_n   <= n_div_n;
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_strobe  = 1'b0;
        n_cmd     = r_cmd;
        n_rsp     = r_rsp;
        n_elem    = r_elem;
        n_lft     = r_lft;
        n_idx     = r_idx;
        n_sidx    = r_sidx;
        n_pv      = r_pv;
        n_pidx    = r_pidx;
        n_hasr    = r_hasr;
        n_budget  = r_budget;
        n_removed = r_removed;
        n_status  = r_status;
        n_flag    = r_flag;
        n_ttl_s   = r_ttl_s;
        n_dvd     = r_dvd;
        n_pr      = r_pr;
        n_div_n   = r_div_n;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = r_elem;
        mem_raddr = '0;

        case (r_state)
            eth_pkg::S_IDLE: begin
                if (start) begin
                    n_cmd     = i_cmd;
                    n_removed = '0;
                    n_status  = eth_pkg::ST_OK;
                    n_flag    = 1'b0;
                    n_ttl_s   = '0;
                    n_sidx    = '0;
                    n_pv      = 1'b0;
                    n_budget  = (32'(i_cmd.budget) > MAX_BUDGET) ? BW'(MAX_BUDGET)
                                                                 : BW'(i_cmd.budget);
                    case (i_cmd.command)
                        eth_pkg::CMD_SET: begin
                            if (i_cmd.ttl_ms == '0) begin
                                n_status = eth_pkg::ST_BAD_TTL;
                                n_state  = eth_pkg::S_DONE;
                            end else begin
                                n_state = eth_pkg::S_SRCH;
                            end
                        end
                        eth_pkg::CMD_DEL,
                        eth_pkg::CMD_ASK_EXP,
                        eth_pkg::CMD_ASK_TTL: n_state = eth_pkg::S_SRCH;
                        eth_pkg::CMD_SWEEP:   n_state = eth_pkg::S_SW_RD;
                        default:              n_state = eth_pkg::S_DONE;
                    endcase
                end
            end

            // linear scan, one read issued per cycle, compare one behind
            eth_pkg::S_SRCH: begin
                mem_raddr = r_sidx[AW-1:0];
                if (r_pv && rd_key == key_in && rd_eng == r_cmd.engine) begin
                    case (r_cmd.command)
                        eth_pkg::CMD_SET: begin
                            n_elem  = {key_in, r_cmd.engine, new_dl};
                            n_idx   = r_pidx;
                            n_state = eth_pkg::S_DN_RL;
                        end
                        eth_pkg::CMD_DEL: begin
                            n_idx   = r_pidx;
                            n_state = eth_pkg::S_RM_START;
                        end
                        eth_pkg::CMD_ASK_EXP: begin
                            n_flag  = now_x >= rd_dl;
                            n_state = eth_pkg::S_DONE;
                        end
                        eth_pkg::CMD_ASK_TTL: begin
                            if (now_x >= rd_dl) begin
                                n_ttl_s = eth_pkg::TTL_GONE;
                                n_state = eth_pkg::S_DONE;
                            end else begin
                                n_dvd   = 64'(rd_dl - now_x);
                                n_pr    = '0;
                                n_div_n = 6'(eth_pkg::DIV_STEPS);
                                n_state = eth_pkg::S_DIV;
                            end
                        end
                        default: n_state = eth_pkg::S_DONE;
                    endcase
                end else if (r_sidx < r_cnt) begin
                    n_sidx = r_sidx + CW'(1);
                    n_pv   = 1'b1;
                    n_pidx = r_sidx[AW-1:0];
                end else if (r_pv) begin
                    n_pv = 1'b0;
                end else begin
                    // key not in the table
                    case (r_cmd.command)
                        eth_pkg::CMD_SET: begin
                            if (r_cnt == CW'(CAPACITY)) begin
                                n_status = eth_pkg::ST_FULL;
                                n_state  = eth_pkg::S_DONE;
                            end else begin
                                n_elem  = {key_in, r_cmd.engine, new_dl};
                                n_idx   = r_cnt[AW-1:0];
                                n_cnt   = r_cnt + CW'(1);
                                n_state = eth_pkg::S_UP_RD;
                            end
                        end
                        eth_pkg::CMD_ASK_TTL: begin
                            n_status = eth_pkg::ST_NOT_FOUND;
                            n_ttl_s  = eth_pkg::TTL_MISSING;
                            n_state  = eth_pkg::S_DONE;
                        end
                        default: begin
                            n_status = eth_pkg::ST_NOT_FOUND;
                            n_state  = eth_pkg::S_DONE;
                        end
                    endcase
                end
            end

            // divide by 1000, one 16-bit quotient digit per cycle
            eth_pkg::S_DIV: begin
                n_pr    = div_rem[9:0];
                n_dvd   = {r_dvd[47:0], div_qd};
                n_div_n = r_div_n - 6'd1;
                if (r_div_n == 6'd1) begin
                    n_state = eth_pkg::S_DIV_END;
                end
            end

            // round up and saturate
            eth_pkg::S_DIV_END: begin
                n_ttl_s = (sec > eth_pkg::TTL_SAT) ? eth_pkg::TTL_W'(eth_pkg::TTL_SAT)
                                                   : eth_pkg::TTL_W'(sec);
                n_state = eth_pkg::S_DONE;
            end

            eth_pkg::S_SW_RD: begin
                if (r_removed < r_budget && r_cnt != '0) begin
                    mem_raddr = '0;
                    n_state   = eth_pkg::S_SW_CHK;
                end else begin
                    n_state = eth_pkg::S_DONE;
                end
            end

            // root due: report it and remove it
            eth_pkg::S_SW_CHK: begin
                if (rd_dl <= now_x) begin
                    n_strobe = 1'b1;
                    n_rsp    = '0;
                    n_rsp.removed_key    = 32'(64'(rd_key));
                    n_rsp.removed_engine = rd_eng;
                    n_removed = r_removed + BW'(1);
                    n_idx     = '0;
                    n_state   = eth_pkg::S_RM_START;
                end else begin
                    n_state = eth_pkg::S_DONE;
                end
            end

            // pull the last slot into the hole at r_idx
            eth_pkg::S_RM_START: begin
                n_cnt = cnt_m1;
                if (CW'(r_idx) == cnt_m1) begin
                    n_state = after_st;
                end else begin
                    mem_raddr = cnt_m1[AW-1:0];
                    n_state   = eth_pkg::S_RM_LD;
                end
            end

            eth_pkg::S_RM_LD: begin
                n_elem  = rd_data;
                n_state = eth_pkg::S_DN_RL;
            end

            eth_pkg::S_DN_RL: begin
                if (lidx < cnt_x) begin
                    mem_raddr = lidx[AW-1:0];
                    n_state   = eth_pkg::S_DN_RR;
                end else begin
                    n_state = eth_pkg::S_UP_RD;
                end
            end

            eth_pkg::S_DN_RR: begin
                n_lft     = rd_data;
                n_hasr    = ridx < cnt_x;
                mem_raddr = ridx[AW-1:0];
                n_state   = eth_pkg::S_DN_DEC;
            end

            // left child wins ties against the right one
            eth_pkg::S_DN_DEC: begin
                if (go_r) begin
                    mem_we    = 1'b1;
                    mem_wdata = rd_data;
                    n_idx     = ridx[AW-1:0];
                    n_state   = eth_pkg::S_DN_RL;
                end else if (go_l) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_lft;
                    n_idx     = lidx[AW-1:0];
                    n_state   = eth_pkg::S_DN_RL;
                end else begin
                    n_state = eth_pkg::S_UP_RD;
                end
            end

            eth_pkg::S_UP_RD: begin
                if (r_idx == '0) begin
                    mem_we  = 1'b1;
                    n_state = after_st;
                end else begin
                    mem_raddr = pidx;
                    n_state   = eth_pkg::S_UP_DEC;
                end
            end

            eth_pkg::S_UP_DEC: begin
                mem_we = 1'b1;
                if (rd_dl <= elem_dl) begin
                    n_state = after_st;
                end else begin
                    mem_wdata = rd_data;
                    n_idx     = pidx;
                    n_state   = eth_pkg::S_UP_RD;
                end
            end

            eth_pkg::S_DONE: begin
                n_strobe = 1'b1;
                n_rsp    = '0;
                n_rsp.status        = r_status;
                n_rsp.expired_flag  = r_flag;
                n_rsp.ttl_seconds   = r_ttl_s;
                n_rsp.removed_count = 5'(r_removed);
                n_rsp.last          = 1'b1;
                n_state             = eth_pkg::S_IDLE;
            end

            default: n_state = eth_pkg::S_IDLE;
        endcase
    end

    assign busy     = r_state != eth_pkg::S_IDLE;
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    // the block is already free while its final beat is on o_rsp
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_rsp.last) |-> !busy)
        else $error("busy after last beat");

    // an accepted command always holds the block
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted without going busy");

    // the table never grows past its slots
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // no slot writes while idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !mem_we)
        else $error("slot write while idle");

    // a sweep never reports more entries than its budget
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_removed <= r_budget || r_cmd.command != eth_pkg::CMD_SWEEP))
        else $error("sweep exceeded budget");

endmodule
